>>> rtl/core/slbs_pkg.sv
`timescale 1ns / 1ps

package slbs_pkg;

    // Field widths of the pixel and result channels
    localparam int LABEL_W   = 6;
    localparam int ID_W      = 7;
    localparam int COUNT_W   = 21;
    localparam int BOX_POS_W = 10;
    localparam int BOX_LEN_W = 11;
    localparam int IWIDTH_W  = 11;

    localparam logic [IWIDTH_W-1:0] IWIDTH_RESET = 11'd640;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FLUSH,
        ST_LOOK,
        ST_TAKE,
        ST_FINISH
    } back_state_t;

endpackage

>>> rtl/core/slbs_if.sv
`timescale 1ns / 1ps

interface slbs_pixel_if import slbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;
    logic               frame_end;

    modport source (output valid, label, frame_end, input ready);
    modport sink (input valid, label, frame_end, output ready);
endinterface

interface slbs_result_if import slbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      compact_id;
    logic [COUNT_W-1:0]   pixel_count;
    logic [BOX_POS_W-1:0] box_x;
    logic [BOX_POS_W-1:0] box_y;
    logic [BOX_LEN_W-1:0] box_width;
    logic [BOX_LEN_W-1:0] box_height;
    logic                 last_segment;

    modport source (output valid, compact_id, pixel_count, box_x, box_y, box_width,
                    box_height, last_segment, input ready);
    modport sink (input valid, compact_id, pixel_count, box_x, box_y, box_width,
                  box_height, last_segment, output ready);
endinterface

>>> rtl/core/segment_label_box_statistics.sv
`timescale 1ns / 1ps
// Per-label pixel count and bounding box over a raster-order label stream.
// pixel channel: one label per transfer, frame_end set on the last pixel of a frame.
// result channel: after a frame ends, one transfer per label present in ascending
//   label order, numbered 1..N, last_segment set on the final one; an empty frame
//   gives no transfer.
// image_width_we / image_width_data: columns per row, written between frames.
// Throughput: one pixel per cycle while the queue is not full; each pixel is a
//   read-modify-write of the label store (one read and one write port), bypassed
//   when the same label repeats. At frame end the back sweeps the store: a flush
//   state, then a look at each of labels 1..MAX_LABELS-1, a take for each present
//   label, and a finish state. Each result is held until the next present label is
//   found or the sweep ends.
// During the sweep the next frame's pixels keep entering until the 4-entry queue
//   fills; then pixel.ready drops.
// A stalled result receiver holds the sweep; one result waits in the output
//   register and one more behind it.
// Reset: store empties at once (per-label present bits), positions return to zero,
//   image_width returns to 640. No clearing pass is needed.
module segment_label_box_statistics import slbs_pkg::*; #(
    parameter int MAX_LABELS = 64,
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    slbs_pixel_if.sink          pixel,
    slbs_result_if.source       result,
    input  logic                image_width_we,
    input  logic [IWIDTH_W-1:0] image_width_data
);

    localparam int ITEM_W = 2 + $clog2(MAX_LABELS) + $clog2(MAX_COLS) + $clog2(MAX_ROWS);

    logic              queue_push;
    logic [ITEM_W-1:0] queue_wdata;
    logic              queue_full;
    logic              queue_pop;
    logic [ITEM_W-1:0] queue_rdata;
    logic              queue_empty;

    slbs_front #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .pixel            (pixel),
        .image_width_we   (image_width_we),
        .image_width_data (image_width_data),
        .queue_full       (queue_full),
        .queue_push       (queue_push),
        .queue_data       (queue_wdata)
    );

    slbs_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (queue_wdata),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_rdata),
        .empty     (queue_empty)
    );

    slbs_back #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (queue_rdata),
        .queue_pop   (queue_pop),
        .result      (result)
    );

endmodule

>>> rtl/core/slbs_ram.sv
`timescale 1ns / 1ps

module slbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/slbs_fifo.sv
`timescale 1ns / 1ps

module slbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;
    logic [AW:0]      cnt_next;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/slbs_front.sv
`timescale 1ns / 1ps

module slbs_front import slbs_pkg::*; #(
    parameter int MAX_LABELS = 64,
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    localparam int LBL_W = $clog2(MAX_LABELS),
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int ROW_W = $clog2(MAX_ROWS),
    localparam int ITEM_W = 2 + LBL_W + COL_W + ROW_W
) (
    input  logic                clk,
    input  logic                rst_n,
    slbs_pixel_if.sink          pixel,
    input  logic                image_width_we,
    input  logic [IWIDTH_W-1:0] image_width_data,
    input  logic                queue_full,
    output logic                queue_push,
    output logic [ITEM_W-1:0]   queue_data
);

    localparam int CMP_W = (COL_W + 1 > IWIDTH_W) ? COL_W + 1 : IWIDTH_W;

    logic [IWIDTH_W-1:0] image_width_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [CMP_W-1:0]    eff_width;
    logic                col_wrap;
    logic                row_last;
    logic                accept;
    logic                hit;
    logic [LBL_W-1:0]    idx;

    assign pixel.ready = !queue_full;
    assign accept      = pixel.valid && !queue_full;

    // Zero acts as one column; clamp to the column capacity
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (CMP_W'(image_width_reg) > CMP_W'(MAX_COLS))
        begin
            eff_width = CMP_W'(MAX_COLS);
        end
        else
        begin
            eff_width = CMP_W'(image_width_reg);
        end
    end

    assign col_wrap = (CMP_W'(col_reg) + CMP_W'(1)) >= eff_width;
    assign row_last = (row_reg == ROW_W'(MAX_ROWS - 1));

    // Drop unassigned labels and labels beyond the store
    assign hit = (pixel.label != '0)
              && ((LABEL_W+1)'(pixel.label) < (LABEL_W+1)'(MAX_LABELS));
    assign idx = pixel.label[LBL_W-1:0];

    assign queue_push = accept && (hit || pixel.frame_end);
    assign queue_data = {pixel.frame_end, hit, idx, col_reg, row_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IWIDTH_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            if (image_width_we)
            begin
                image_width_reg <= image_width_data;
            end
            if (accept)
            begin
                if (pixel.frame_end)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (col_wrap)
                begin
                    col_reg <= '0;
                    if (!row_last)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/slbs_back.sv
`timescale 1ns / 1ps

module slbs_back import slbs_pkg::*; #(
    parameter int MAX_LABELS = 64,
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    localparam int LBL_W = $clog2(MAX_LABELS),
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int ROW_W = $clog2(MAX_ROWS),
    localparam int ITEM_W = 2 + LBL_W + COL_W + ROW_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  logic [ITEM_W-1:0] queue_data,
    output logic              queue_pop,
    slbs_result_if.source     result
);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COL_W-1:0]   min_col;
        logic [COL_W-1:0]   max_col;
        logic [ROW_W-1:0]   min_row;
        logic [ROW_W-1:0]   max_row;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [LBL_W-1:0] LAST_LABEL = LBL_W'(MAX_LABELS - 1);

    // Queue head
    logic             head_fe;
    logic             head_hit;
    logic [LBL_W-1:0] head_idx;
    logic [COL_W-1:0] head_col;
    logic [ROW_W-1:0] head_row;

    // Update stage
    logic             s2_valid_reg;
    logic             s2_hit_reg;
    logic [LBL_W-1:0] s2_idx_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic             fwd_valid_reg;
    logic [LBL_W-1:0] fwd_idx_reg;
    entry_t           fwd_data_reg;
    entry_t           base;
    entry_t           upd;
    logic             wen;

    logic [MAX_LABELS-1:0] seen_reg;
    logic [LBL_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    // Scan control
    back_state_t      state_reg;
    back_state_t      state_next;
    logic [LBL_W-1:0] cursor_reg;
    logic [LBL_W-1:0] cursor_next;
    logic             place;
    logic             out_load;
    logic             out_last;
    logic             finish_clear;
    logic             out_free;

    logic [ID_W-1:0]      id_reg;
    logic                 held_valid_reg;
    logic [ID_W-1:0]      held_id_reg;
    logic [COUNT_W-1:0]   held_count_reg;
    logic [BOX_POS_W-1:0] held_x_reg;
    logic [BOX_POS_W-1:0] held_y_reg;
    logic [BOX_LEN_W-1:0] held_w_reg;
    logic [BOX_LEN_W-1:0] held_h_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [BOX_POS_W-1:0] out_x_reg;
    logic [BOX_POS_W-1:0] out_y_reg;
    logic [BOX_LEN_W-1:0] out_w_reg;
    logic [BOX_LEN_W-1:0] out_h_reg;
    logic                 out_last_reg;

    assign head_fe  = queue_data[ITEM_W-1];
    assign head_hit = queue_data[ITEM_W-2];
    assign head_idx = queue_data[COL_W+ROW_W +: LBL_W];
    assign head_col = queue_data[ROW_W +: COL_W];
    assign head_row = queue_data[0 +: ROW_W];

    assign ram_raddr = (state_reg == ST_RUN) ? head_idx : cursor_reg;
    assign rd_entry  = entry_t'(ram_rdata);

    slbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LABELS)
    ) u_store (
        .clk   (clk),
        .we    (wen),
        .waddr (s2_idx_reg),
        .wdata (ENTRY_W'(upd)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read-modify-write; take the entry written last cycle from the bypass
    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s2_idx_reg))
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rd_entry;
        end

        upd = base;
        if (!seen_reg[s2_idx_reg])
        begin
            upd.count   = COUNT_W'(1);
            upd.min_col = s2_col_reg;
            upd.max_col = s2_col_reg;
            upd.min_row = s2_row_reg;
            upd.max_row = s2_row_reg;
        end
        else
        begin
            if (s2_col_reg < base.min_col)
            begin
                upd.min_col = s2_col_reg;
            end
            if (s2_col_reg > base.max_col)
            begin
                upd.max_col = s2_col_reg;
            end
            if (s2_row_reg < base.min_row)
            begin
                upd.min_row = s2_row_reg;
            end
            if (s2_row_reg > base.max_row)
            begin
                upd.max_row = s2_row_reg;
            end
            if (base.count != COUNT_MAX)
            begin
                upd.count = base.count + 1'b1;
            end
        end
    end

    assign wen      = s2_valid_reg && s2_hit_reg;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        queue_pop    = 1'b0;
        place        = 1'b0;
        out_load     = 1'b0;
        out_last     = 1'b0;
        finish_clear = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (!queue_empty)
                begin
                    queue_pop = 1'b1;
                    if (head_fe)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                // Let the frame-end pixel land in the store
                cursor_next = LBL_W'(1);
                state_next  = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (seen_reg[cursor_reg])
                begin
                    state_next = ST_TAKE;
                end
                else if (cursor_reg == LAST_LABEL)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            ST_TAKE:
            begin
                // Hold one result back so the final one can be marked
                if (!held_valid_reg || out_free)
                begin
                    place    = 1'b1;
                    out_load = held_valid_reg;
                    if (cursor_reg == LAST_LABEL)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + 1'b1;
                        state_next  = ST_LOOK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    out_load     = held_valid_reg;
                    out_last     = 1'b1;
                    finish_clear = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            cursor_reg     <= '0;
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            seen_reg       <= '0;
            id_reg         <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            s2_valid_reg  <= queue_pop;
            fwd_valid_reg <= wen;
            if (finish_clear)
            begin
                seen_reg       <= '0;
                id_reg         <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                if (wen)
                begin
                    seen_reg[s2_idx_reg] <= 1'b1;
                end
                if (place)
                begin
                    id_reg         <= id_reg + 1'b1;
                    held_valid_reg <= 1'b1;
                end
            end
            out_valid_reg <= out_load || (out_valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            s2_hit_reg <= head_hit;
            s2_idx_reg <= head_idx;
            s2_col_reg <= head_col;
            s2_row_reg <= head_row;
        end
        if (wen)
        begin
            fwd_idx_reg  <= s2_idx_reg;
            fwd_data_reg <= upd;
        end
        if (place)
        begin
            held_id_reg    <= id_reg + 1'b1;
            held_count_reg <= rd_entry.count;
            held_x_reg     <= BOX_POS_W'(rd_entry.min_col);
            held_y_reg     <= BOX_POS_W'(rd_entry.min_row);
            held_w_reg     <= BOX_LEN_W'({1'b0, rd_entry.max_col}
                              - {1'b0, rd_entry.min_col} + (COL_W+1)'(1));
            held_h_reg     <= BOX_LEN_W'({1'b0, rd_entry.max_row}
                              - {1'b0, rd_entry.min_row} + (ROW_W+1)'(1));
        end
        if (out_load)
        begin
            out_id_reg    <= held_id_reg;
            out_count_reg <= held_count_reg;
            out_x_reg     <= held_x_reg;
            out_y_reg     <= held_y_reg;
            out_w_reg     <= held_w_reg;
            out_h_reg     <= held_h_reg;
            out_last_reg  <= out_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.compact_id   = out_id_reg;
    assign result.pixel_count  = out_count_reg;
    assign result.box_x        = out_x_reg;
    assign result.box_y        = out_y_reg;
    assign result.box_width    = out_w_reg;
    assign result.box_height   = out_h_reg;
    assign result.last_segment = out_last_reg;

endmodule
